// ----- src/sbrx_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and structs of the SBUS receiver.
package sbrx_pkg;

  localparam int unsigned FrameLen = 25;
  localparam int unsigned PosW     = $clog2(FrameLen + 1);
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ChW      = 11;
  localparam int unsigned NumCh    = 16;
  localparam int unsigned NumFlags = 4;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned ScaleW   = 24;
  localparam int unsigned DbW      = 15;
  localparam int unsigned PosOutW  = 16;
  localparam int unsigned CntW     = 16;
  localparam int unsigned AccW     = ChW + ScaleW;
  localparam int unsigned FracW    = 16;
  localparam int unsigned MagW     = AccW - FracW;
  localparam int unsigned BitPtrW  = 8;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned ChCntW   = 4;
  localparam int unsigned FlagCntW = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [ByteW-1:0]   Header      = 8'h0F;
  localparam logic [PosW-1:0]    FlagByteIdx = 5'd23;
  localparam logic [BitPtrW-1:0] FirstChBit  = 8'd8;
  localparam logic [ChCntW-1:0]  WatchCh     = 4'd2;
  localparam logic [AccW-1:0]    RoundInit   = AccW'(32768);

  localparam logic [PosOutW-1:0] PosMax = 16'h7FFF;
  localparam logic [PosOutW-1:0] PosMin = 16'h8000;

  localparam logic [ChW-1:0]    CenterRst   = 11'd992;
  localparam logic [ScaleW-1:0] ScaleRst    = 24'd3834792;
  localparam logic [DbW-1:0]    DeadbandRst = 15'd328;
  localparam logic [ChW-1:0]    FailsafeRst = 11'd32;
  localparam logic [CntW-1:0]   LimitRst    = 16'd100;
  localparam logic [ChW-1:0]    WatchRst    = 11'd32;

  localparam logic KindChannel = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CMD_BYTE = 2'd0,
    CMD_IDLE = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER   = 3'd0,
    CFG_SCALE    = 3'd1,
    CFG_DEADBAND = 3'd2,
    CFG_FAILSAFE = 3'd3,
    CFG_LIMIT    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ChW-1:0]    center;
    logic [ScaleW-1:0] scale;
    logic [DbW-1:0]    deadband;
    logic [ChW-1:0]    failsafe;
    logic [CntW-1:0]   limit;
  } cfg_t;

  typedef struct packed {
    logic               byte_we;
    logic [ByteW-1:0]   byte_data;
    logic               pos_clear;
    logic [BitPtrW-1:0] bit_addr;
  } fs_ctrl_t;

  typedef struct packed {
    logic                bit_val;
    logic                frame_ok;
    logic [NumFlags-1:0] flags;
  } fs_stat_t;

  typedef struct packed {
    logic           start;
    logic [ChW-1:0] raw;
  } pos_req_t;

  typedef struct packed {
    logic               done;
    logic [PosOutW-1:0] position;
  } pos_rsp_t;

  typedef struct packed {
    logic           tick;
    logic           load;
    logic [ChW-1:0] load_value;
  } wd_ctrl_t;

  typedef struct packed {
    logic [ChW-1:0] watched;
    logic           offline;
  } wd_stat_t;

  typedef struct packed {
    logic               result_kind;
    logic [IdxW-1:0]    channel_index;
    logic [ChW-1:0]     raw_value;
    logic [PosOutW-1:0] position;
    logic               offline;
    logic               last;
  } res_t;

endpackage

// ----- src/sbrx_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: received bytes, line idle and protect ticks.
interface sbrx_in_if;
  logic                       valid;
  logic                       ready;
  logic [sbrx_pkg::CmdW-1:0]  command;
  logic [sbrx_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

// ----- src/sbrx_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: decoded channel and watchdog status words.
interface sbrx_out_if;
  logic                               valid;
  logic                               ready;
  logic                               result_kind;
  logic [sbrx_pkg::IdxW-1:0]          channel_index;
  logic [sbrx_pkg::ChW-1:0]           raw_value;
  logic signed [sbrx_pkg::PosOutW-1:0] position;
  logic                               offline;
  logic                               last;

  modport source (output valid, result_kind, channel_index, raw_value, position, offline, last,
                  input ready);
  modport sink   (input valid, result_kind, channel_index, raw_value, position, offline, last,
                  output ready);
endinterface

// ----- src/sbrx_frame_store.sv -----
`timescale 1ns / 1ps
// 25-byte frame store with byte write pointer and single-bit read port.
module sbrx_frame_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbrx_pkg::fs_ctrl_t ctrl_i,
  output sbrx_pkg::fs_stat_t stat_o
);
  import sbrx_pkg::*;

  logic [ByteW-1:0] mem_q [FrameLen];
  logic [PosW-1:0]  wpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FrameLen; i++) begin
        mem_q[i] <= '0;
      end
      wpos_q <= '0;
    end else begin
      if (ctrl_i.pos_clear) begin
        wpos_q <= '0;
      end else if (ctrl_i.byte_we && (wpos_q < PosW'(FrameLen))) begin
        mem_q[wpos_q] <= ctrl_i.byte_data;
        wpos_q        <= wpos_q + 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.bit_val  = mem_q[ctrl_i.bit_addr[BitPtrW-1:3]][ctrl_i.bit_addr[2:0]];
    stat_o.frame_ok = (mem_q[0] == Header) && (mem_q[FrameLen-1] == '0);
    // flag i is bit 7-i of byte 23
    for (int i = 0; i < NumFlags; i++) begin
      stat_o.flags[i] = mem_q[FlagByteIdx][ByteW-1-i];
    end
  end

endmodule

// ----- src/sbrx_pos_unit.sv -----
`timescale 1ns / 1ps
// Shift-add stick scaler: |raw-center|*scale one bit per cycle, then deadband and clamp.
module sbrx_pos_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbrx_pkg::cfg_t     cfg_i,
  input  sbrx_pkg::pos_req_t req_i,
  output sbrx_pkg::pos_rsp_t rsp_o
);
  import sbrx_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [BitCntW-1:0] cnt_q;
  logic [ChW-1:0]     mag_q;
  logic               neg_q;
  logic [AccW-1:0]    acc_q;
  logic [AccW-1:0]    sc_q;
  logic [MagW-1:0]    m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == BitCntW'(ChW - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == BitCntW'(ChW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // accumulator starts at one half LSB of the result, so rounding is free
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.raw < cfg_i.center;
      mag_q <= (req_i.raw < cfg_i.center) ? (cfg_i.center - req_i.raw)
                                          : (req_i.raw - cfg_i.center);
      acc_q <= RoundInit;
      sc_q  <= AccW'(cfg_i.scale);
    end else if (busy_q) begin
      if (mag_q[0]) begin
        acc_q <= acc_q + sc_q;
      end
      mag_q <= mag_q >> 1;
      sc_q  <= sc_q << 1;
    end
  end

  always_comb begin
    m = acc_q[AccW-1:FracW];
    if (m <= MagW'(cfg_i.deadband)) begin
      rsp_o.position = '0;
    end else if (neg_q) begin
      if (m >= MagW'(PosMin)) begin
        rsp_o.position = PosMin;
      end else begin
        rsp_o.position = ~m[PosOutW-1:0] + 1'b1;
      end
    end else if (m >= MagW'(PosMax)) begin
      rsp_o.position = PosMax;
    end else begin
      rsp_o.position = m[PosOutW-1:0];
    end
    rsp_o.done = done_q;
  end

endmodule

// ----- src/sbrx_watchdog.sv -----
`timescale 1ns / 1ps
// Failsafe watchdog: watched channel 2, saturating tick counter, offline flag.
module sbrx_watchdog (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbrx_pkg::cfg_t     cfg_i,
  input  sbrx_pkg::wd_ctrl_t ctrl_i,
  output sbrx_pkg::wd_stat_t stat_o
);
  import sbrx_pkg::*;

  logic [ChW-1:0]  watch_q, watch_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            off_q, off_d;

  always_comb begin
    watch_d = watch_q;
    cnt_d   = cnt_q;
    off_d   = off_q;
    if (ctrl_i.load) begin
      watch_d = ctrl_i.load_value;
    end
    if (ctrl_i.tick) begin
      if (watch_q == cfg_i.failsafe) begin
        if (cnt_q != '1) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        cnt_d = '0;
        off_d = 1'b0;
      end
      if (cnt_d >= cfg_i.limit) begin
        off_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_q <= WatchRst;
      cnt_q   <= '0;
      off_q   <= 1'b0;
    end else begin
      watch_q <= watch_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
    end
  end

  assign stat_o.watched = watch_q;
  assign stat_o.offline = off_q;

endmodule

// ----- src/sbrx_sequencer.sv -----
`timescale 1ns / 1ps
// Configuration register bank of the SBUS receiver.
module sbrx_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbrx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sbrx_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sbrx_pkg::cfg_t                cfg_o
);
  import sbrx_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center   <= CenterRst;
      cfg_q.scale    <= ScaleRst;
      cfg_q.deadband <= DeadbandRst;
      cfg_q.failsafe <= FailsafeRst;
      cfg_q.limit    <= LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER:   cfg_q.center   <= cfg_wdata_i[ChW-1:0];
        CFG_SCALE:    cfg_q.scale    <= cfg_wdata_i[ScaleW-1:0];
        CFG_DEADBAND: cfg_q.deadband <= cfg_wdata_i[DbW-1:0];
        CFG_FAILSAFE: cfg_q.failsafe <= cfg_wdata_i[ChW-1:0];
        CFG_LIMIT:    cfg_q.limit    <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/sbus_receiver_with_failsafe.sv -----
`timescale 1ns / 1ps
// SBUS frame receiver with bit-serial channel unpack, stick scaling and failsafe watchdog.
//
// in_i carries one word per event: command 0 stores rx_byte in the next of 25 frame
// slots (later bytes are dropped), command 1 marks line idle and ends the frame,
// command 2 is a protect tick, command 3 is ignored. After a byte or an ignored word
// the sequencer stays idle. A good frame (header 0x0F, last byte 0) sends 20 words on
// out_o: channels 0..15 with raw value and Q1.15 position, then flags 16..19, the last
// one marked. Each channel is shifted out of the store one bit per cycle, then scaled
// in the shift-add scaler, then emitted. A bad frame sends nothing and leaves the
// sequencer idle. A tick moves the sequencer to ST_TICK, which loads the status word
// into the output register once it is free. in_i.ready is high only between items.
// The output register holds one word; when out_o stalls the sequencer waits in place
// and no new input is taken until the last word of the item is in the output register.
// Reset clears the frame store and byte pointer, resets the watchdog and loads the register
// defaults; configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
module sbus_receiver_with_failsafe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sbrx_in_if.sink                       in_i,
  sbrx_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [sbrx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sbrx_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sbrx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNPACK,
    ST_MULT,
    ST_EMIT_CH,
    ST_FLAGS,
    ST_TICK
  } state_e;

  state_e              state_q, state_d;
  logic [BitPtrW-1:0]  bit_ptr_q, bit_ptr_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [ChCntW-1:0]   ch_q, ch_d;
  logic [FlagCntW-1:0] flag_q, flag_d;
  logic [ChW-1:0]      raw_q, raw_d;
  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;

  cfg_t     cfg;
  fs_ctrl_t fs_ctrl;
  fs_stat_t fs_stat;
  pos_req_t pos_req;
  pos_rsp_t pos_rsp;
  wd_ctrl_t wd_ctrl;
  wd_stat_t wd_stat;

  logic           in_acc;
  logic           out_free;
  logic [ChW-1:0] raw_shift;

  sbrx_sequencer u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sbrx_frame_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fs_ctrl),
    .stat_o (fs_stat)
  );

  sbrx_pos_unit u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (pos_req),
    .rsp_o  (pos_rsp)
  );

  sbrx_watchdog u_wd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .ctrl_i (wd_ctrl),
    .stat_o (wd_stat)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  // channel bits come out LSB first
  assign raw_shift  = {fs_stat.bit_val, raw_q[ChW-1:1]};

  always_comb begin
    state_d     = state_q;
    bit_ptr_d   = bit_ptr_q;
    bit_cnt_d   = bit_cnt_q;
    ch_d        = ch_q;
    flag_d      = flag_q;
    raw_d       = raw_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;

    fs_ctrl.byte_we   = 1'b0;
    fs_ctrl.byte_data = in_i.rx_byte;
    fs_ctrl.pos_clear = 1'b0;
    fs_ctrl.bit_addr  = bit_ptr_q;
    pos_req.start     = 1'b0;
    pos_req.raw       = raw_shift;
    wd_ctrl.tick       = 1'b0;
    wd_ctrl.load       = 1'b0;
    wd_ctrl.load_value = raw_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.command)
            CMD_BYTE: begin
              fs_ctrl.byte_we = 1'b1;
            end
            CMD_IDLE: begin
              fs_ctrl.pos_clear = 1'b1;
              if (fs_stat.frame_ok) begin
                bit_ptr_d = FirstChBit;
                bit_cnt_d = '0;
                ch_d      = '0;
                state_d   = ST_UNPACK;
              end
            end
            CMD_TICK: begin
              wd_ctrl.tick = 1'b1;
              state_d      = ST_TICK;
            end
            default: ;
          endcase
        end
      end
      ST_UNPACK: begin
        raw_d     = raw_shift;
        bit_ptr_d = bit_ptr_q + 1'b1;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitCntW'(ChW - 1)) begin
          pos_req.start = 1'b1;
          bit_cnt_d     = '0;
          state_d       = ST_MULT;
        end
      end
      ST_MULT: begin
        if (pos_rsp.done) begin
          state_d = ST_EMIT_CH;
        end
      end
      ST_EMIT_CH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.result_kind   = KindChannel;
          res_d.channel_index = IdxW'(ch_q);
          res_d.raw_value     = raw_q;
          res_d.position      = pos_rsp.position;
          res_d.offline       = 1'b0;
          res_d.last          = 1'b0;
          if (ch_q == WatchCh) begin
            wd_ctrl.load = 1'b1;
          end
          if (ch_q == ChCntW'(NumCh - 1)) begin
            flag_d  = '0;
            state_d = ST_FLAGS;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_UNPACK;
          end
        end
      end
      ST_FLAGS: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.result_kind   = KindChannel;
          res_d.channel_index = IdxW'(NumCh) + IdxW'(flag_q);
          res_d.raw_value     = ChW'(fs_stat.flags[flag_q]);
          res_d.position      = '0;
          res_d.offline       = 1'b0;
          res_d.last          = (flag_q == FlagCntW'(NumFlags - 1));
          if (flag_q == FlagCntW'(NumFlags - 1)) begin
            state_d = ST_IDLE;
          end else begin
            flag_d = flag_q + 1'b1;
          end
        end
      end
      ST_TICK: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.result_kind   = KindStatus;
          res_d.channel_index = '0;
          res_d.raw_value     = wd_stat.watched;
          res_d.position      = '0;
          res_d.offline       = wd_stat.offline;
          res_d.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_ptr_q   <= '0;
      bit_cnt_q   <= '0;
      ch_q        <= '0;
      flag_q      <= '0;
      raw_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      bit_ptr_q   <= bit_ptr_d;
      bit_cnt_q   <= bit_cnt_d;
      ch_q        <= ch_d;
      flag_q      <= flag_d;
      raw_q       <= raw_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = res_q.result_kind;
  assign out_o.channel_index = res_q.channel_index;
  assign out_o.raw_value     = res_q.raw_value;
  assign out_o.position      = res_q.position;
  assign out_o.offline       = res_q.offline;
  assign out_o.last          = res_q.last;

`ifndef NO_ASSERTIONS
  a_done_in_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_rsp.done |-> (state_q == ST_MULT))
    else $error("scaler finished outside multiply phase");

  a_flag_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.result_kind == KindChannel) && (out_o.channel_index >= IdxW'(NumCh)))
    |-> (out_o.position == '0))
    else $error("flag word carries a nonzero position");

  a_last_is_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last && (out_o.result_kind == KindChannel))
    |-> (out_o.channel_index == IdxW'(NumCh + NumFlags - 1)))
    else $error("frame marked last before final flag");

  a_ptr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNPACK) |-> (bit_ptr_q < BitPtrW'(8 + ChW * NumCh)))
    else $error("bit pointer ran past the channel area");

  a_bad_frame_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.command == CMD_IDLE) && !fs_stat.frame_ok) |=> (state_q == ST_IDLE))
    else $error("bad frame started a decode");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the SBUS receiver: frame decode, stick scaling and failsafe watchdog.
module tb_top;
  import sbrx_pkg::*;

  localparam logic [CmdW-1:0] CmdIgnored = 2'd3;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned DrainHold  = 10;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned PhaseItems = 16;
  localparam int unsigned FlatW      = ByteW * FrameLen;
  localparam int unsigned NumWords   = NumCh + NumFlags;

  typedef logic [ByteW-1:0] frame_t [FrameLen];
  typedef logic [ChW-1:0]   chans_t [NumCh];

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sbrx_in_if  in_if ();
  sbrx_out_if out_if ();

  sbus_receiver_with_failsafe dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // decoder image kept by the bench
  logic [ByteW-1:0] frame_bytes [FrameLen];
  logic [PosW-1:0]  wr_ptr;
  logic [ChW-1:0]   watch_val;
  logic [CntW-1:0]  fs_ticks;
  logic             off_flag;
  cfg_t             model_cfg;
  res_t             pending_words [$];
  res_t             due_word;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned ready_mode;
  int unsigned mode_left;
  int unsigned stall_left;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [PosOutW-1:0] scaled_position(logic [ChW-1:0] raw);
    logic        below;
    logic [ChW-1:0] mag;
    logic [63:0] m;
    below = raw < model_cfg.center;
    mag   = below ? model_cfg.center - raw : raw - model_cfg.center;
    m     = (64'(mag) * 64'(model_cfg.scale) + 64'd32768) >> FracW;
    if (m <= 64'(model_cfg.deadband)) return '0;
    if (below) begin
      if (m > 64'd32768) m = 64'd32768;
      return PosOutW'(64'd0 - m);
    end
    if (m > 64'(PosMax)) m = 64'(PosMax);
    return PosOutW'(m);
  endfunction

  task automatic decode_event(logic [CmdW-1:0] c, logic [ByteW-1:0] b);
    logic [FlatW-1:0] flat;
    logic [ChW-1:0]   raw;
    res_t             w;
    case (c)
      CMD_BYTE: begin
        if (wr_ptr < FrameLen) begin
          frame_bytes[wr_ptr] = b;
          wr_ptr = wr_ptr + 1'b1;
        end
      end
      CMD_IDLE: begin
        wr_ptr = '0;
        if (frame_bytes[0] == Header && frame_bytes[FrameLen-1] == '0) begin
          for (int i = 0; i < FrameLen; i++) flat[ByteW*i +: ByteW] = frame_bytes[i];
          for (int k = 0; k < NumWords; k++) begin
            w = '0;
            w.result_kind   = KindChannel;
            w.channel_index = IdxW'(k);
            if (k < NumCh) begin
              raw = flat[FirstChBit + ChW*k +: ChW];
              w.raw_value = raw;
              w.position  = scaled_position(raw);
            end else begin
              // flags come from the top nibble of byte 23, msb first
              w.raw_value = ChW'(frame_bytes[FlagByteIdx][ByteW-1-(k-NumCh)]);
            end
            w.last = (k == NumWords - 1);
            pending_words.push_back(w);
          end
          watch_val = flat[FirstChBit + ChW*WatchCh +: ChW];
        end
      end
      CMD_TICK: begin
        if (watch_val == model_cfg.failsafe) begin
          if (fs_ticks != '1) fs_ticks = fs_ticks + 1'b1;
        end else begin
          fs_ticks = '0;
          off_flag = 1'b0;
        end
        if (fs_ticks >= model_cfg.limit) off_flag = 1'b1;
        w = '0;
        w.result_kind = KindStatus;
        w.raw_value   = watch_val;
        w.offline     = off_flag;
        w.last        = 1'b1;
        pending_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        $error("word with no expectation: kind %0d index %0d raw %0d",
               out_if.result_kind, out_if.channel_index, out_if.raw_value);
        error_count++;
      end else begin
        due_word = pending_words.pop_front();
        check_field("result_kind", longint'(due_word.result_kind),
                    longint'(out_if.result_kind));
        check_field("channel_index", longint'(due_word.channel_index),
                    longint'(out_if.channel_index));
        check_field("raw_value", longint'(due_word.raw_value), longint'(out_if.raw_value));
        check_field("position", longint'($signed(due_word.position)),
                    longint'(out_if.position));
        check_field("offline", longint'(due_word.offline), longint'(out_if.offline));
        check_field("last", longint'(due_word.last), longint'(out_if.last));
      end
    end
  end

  // output backpressure: switches between several stall patterns
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    if (ready_mode == 0) begin
      out_if.ready <= 1'b1;
    end else if (ready_mode == 1) begin
      out_if.ready <= 1'($urandom_range(0, 1));
    end else if (ready_mode == 2) begin
      out_if.ready <= ($urandom_range(0, 4) != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic [CmdW-1:0] c, logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_if.valid   = 1'b1;
    in_if.command = c;
    in_if.rx_byte = b;
    do @(posedge clk_i); while (!in_if.ready);
    decode_event(c, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (DrainHold) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_CENTER:   model_cfg.center   = val[ChW-1:0];
      CFG_SCALE:    model_cfg.scale    = val[ScaleW-1:0];
      CFG_DEADBAND: model_cfg.deadband = val[DbW-1:0];
      CFG_FAILSAFE: model_cfg.failsafe = val[ChW-1:0];
      CFG_LIMIT:    model_cfg.limit    = val[CntW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [ChW-1:0] center, logic [ScaleW-1:0] scale,
                            logic [DbW-1:0] deadband, logic [ChW-1:0] failsafe,
                            logic [CntW-1:0] limit);
    wait_drained();
    write_reg(CFG_CENTER, CfgDataW'(center));
    write_reg(CFG_SCALE, CfgDataW'(scale));
    write_reg(CFG_DEADBAND, CfgDataW'(deadband));
    write_reg(CFG_FAILSAFE, CfgDataW'(failsafe));
    write_reg(CFG_LIMIT, CfgDataW'(limit));
  endtask

  function automatic chans_t pick_chans();
    chans_t ch;
    for (int k = 0; k < NumCh; k++) begin
      case ($urandom_range(0, 5))
        0:       ch[k] = '0;
        1:       ch[k] = '1;
        2:       ch[k] = model_cfg.center;
        3:       ch[k] = ChW'(model_cfg.center + $urandom_range(0, 40) - 20);
        default: ch[k] = ChW'($urandom_range(0, 2047));
      endcase
    end
    if ($urandom_range(0, 2) == 0) ch[WatchCh] = model_cfg.failsafe;
    return ch;
  endfunction

  function automatic frame_t build_frame(logic [ByteW-1:0] head, chans_t ch,
                                         logic [ByteW-1:0] flags, logic [ByteW-1:0] trail);
    logic [FlatW-1:0] flat;
    frame_t           f;
    flat = '0;
    flat[ByteW-1:0] = head;
    for (int k = 0; k < NumCh; k++) flat[FirstChBit + ChW*k +: ChW] = ch[k];
    flat[ByteW*FlagByteIdx +: ByteW]  = flags;
    flat[ByteW*(FrameLen-1) +: ByteW] = trail;
    for (int i = 0; i < FrameLen; i++) f[i] = flat[ByteW*i +: ByteW];
    return f;
  endfunction

  // bytes past the store length are random and must be dropped
  task automatic send_frame(frame_t f, int unsigned nbytes, bit mix_ticks);
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (mix_ticks && $urandom_range(0, 19) == 0) send_word(CMD_TICK, ByteW'($urandom));
      send_word(CMD_BYTE, (i < FrameLen) ? f[i] : ByteW'($urandom));
    end
    send_word(CMD_IDLE, ByteW'($urandom));
  endtask

  task automatic test_idle_and_ignored();
    repeat (3) send_word(CMD_TICK, 8'hFF);
    send_word(CMD_IDLE, 8'h00);
    send_word(CmdIgnored, 8'hFF);
    send_word(CmdIgnored, 8'h00);
    send_word(CMD_TICK, 8'h00);
  endtask

  task automatic test_frame_layout();
    chans_t ch;
    frame_t f;
    foreach (ch[k]) ch[k] = '1;
    send_frame(build_frame(Header, ch, 8'hA5, 8'h00), FrameLen + 1, 1'b0);
    send_word(CMD_TICK, 8'h55);
    // short frame lands on top of the previous one
    foreach (ch[k]) ch[k] = '0;
    send_frame(build_frame(Header, ch, 8'h5A, 8'h00), 4, 1'b0);
    f = build_frame(8'hF0, ch, 8'h00, 8'h00);
    send_frame(f, 1, 1'b0);
    send_word(CMD_TICK, 8'hAA);
  endtask

  task automatic test_scaling();
    chans_t ch;
    // unity gain: deadband edge on both sides
    set_config(11'd1000, 24'd65536, 15'd5, FailsafeRst, LimitRst);
    ch = pick_chans();
    ch[0] = 11'd1005;
    ch[1] = 11'd1006;
    ch[2] = 11'd995;
    ch[3] = 11'd994;
    ch[4] = 11'd1000;
    ch[5] = 11'd0;
    ch[6] = 11'd2047;
    send_frame(build_frame(Header, ch, ByteW'($urandom), 8'h00), FrameLen, 1'b0);
    // half gain: ties round away from zero
    set_config(11'd1000, 24'd32768, 15'd0, FailsafeRst, LimitRst);
    ch[0] = 11'd1001;
    ch[1] = 11'd999;
    ch[2] = 11'd1003;
    ch[3] = 11'd997;
    send_frame(build_frame(Header, ch, ByteW'($urandom), 8'h00), FrameLen, 1'b0);
    set_config(11'd0, 24'hFFFFFF, 15'd0, 11'd0, 16'd0);
    send_frame(build_frame(Header, pick_chans(), ByteW'($urandom), 8'h00), FrameLen, 1'b0);
    set_config(11'd2047, 24'hFFFFFF, 15'h7FFF, 11'd2047, 16'hFFFF);
    send_frame(build_frame(Header, pick_chans(), ByteW'($urandom), 8'h00), FrameLen, 1'b0);
    set_config(11'd2047, 24'd0, 15'd0, FailsafeRst, LimitRst);
    send_frame(build_frame(Header, pick_chans(), ByteW'($urandom), 8'h00), FrameLen, 1'b0);
  endtask

  task automatic test_offline_watchdog();
    chans_t ch;
    set_config(CenterRst, ScaleRst, DeadbandRst, 11'd0, 16'd3);
    ch = pick_chans();
    ch[WatchCh] = 11'd0;
    send_frame(build_frame(Header, ch, ByteW'($urandom), 8'h00), FrameLen, 1'b0);
    repeat (5) send_word(CMD_TICK, ByteW'($urandom));
    ch[WatchCh] = 11'd5;
    send_frame(build_frame(Header, ch, ByteW'($urandom), 8'h00), FrameLen, 1'b0);
    send_word(CMD_TICK, ByteW'($urandom));
    // a zero limit flags offline even without the failsafe value
    set_config(CenterRst, ScaleRst, DeadbandRst, 11'd0, 16'd0);
    repeat (2) send_word(CMD_TICK, ByteW'($urandom));
    // top limit: the failsafe ticks sent here do not reach it
    set_config(CenterRst, ScaleRst, DeadbandRst, 11'd5, 16'hFFFF);
    repeat (3) send_word(CMD_TICK, ByteW'($urandom));
  endtask

  task automatic test_random_traffic();
    chans_t      ch;
    frame_t      f;
    int unsigned sel;
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0) begin
        set_config(CenterRst, ScaleRst, DeadbandRst, FailsafeRst, LimitRst);
      end else begin
        set_config(ChW'($urandom_range(0, 2047)),
                   (phase == 1) ? ScaleW'($urandom_range(0, 24'hFFFFFF))
                                : ScaleW'($urandom_range(1_000_000, 8_000_000)),
                   DbW'($urandom_range(0, 2000)), ChW'($urandom_range(0, 2047)),
                   CntW'($urandom_range(0, 6)));
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        sel = $urandom_range(0, 99);
        ch  = pick_chans();
        if (sel < 55) begin
          send_frame(build_frame(Header, ch, ByteW'($urandom), 8'h00),
                     ($urandom_range(0, 7) == 0) ? FrameLen + $urandom_range(1, 4) : FrameLen,
                     1'b1);
        end else if (sel < 65) begin
          send_frame(build_frame(Header, ch, ByteW'($urandom), 8'h00),
                     $urandom_range(1, FrameLen - 1), 1'b1);
        end else if (sel < 75) begin
          f = build_frame(Header, ch, ByteW'($urandom), 8'h00);
          if ($urandom_range(0, 1) == 0) begin
            do f[0] = ByteW'($urandom); while (f[0] == Header);
          end else begin
            f[FrameLen-1] = ByteW'($urandom_range(1, 255));
          end
          send_frame(f, FrameLen, 1'b0);
        end else if (sel < 90) begin
          repeat ($urandom_range(1, 6)) send_word(CMD_TICK, ByteW'($urandom));
        end else if (sel < 96) begin
          repeat ($urandom_range(1, 8)) send_word(CmdW'($urandom_range(0, 3)), ByteW'($urandom));
        end else begin
          wait_drained();
        end
      end
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.command = CMD_BYTE;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_CENTER;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    wr_ptr    = '0;
    watch_val = WatchRst;
    fs_ticks  = '0;
    off_flag  = 1'b0;
    model_cfg = '{center: CenterRst, scale: ScaleRst, deadband: DeadbandRst,
                  failsafe: FailsafeRst, limit: LimitRst};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_and_ignored();
    test_frame_layout();
    test_scaling();
    test_offline_watchdog();
    test_random_traffic();

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
